[hdl/klc_pkg.sv]
// Shared types, constants and key decode for the keypad code lock controller.
package klc_pkg;

  // Stream widths
  localparam int unsigned InTdataW  = 24;  // key_code, hour_now, distance_cm, zero fill
  localparam int unsigned InTuserW  = 2;   // req_type
  localparam int unsigned OutTdataW = 16;  // result fields, zero fill
  localparam int unsigned ResW      = 11;  // packed result bits

  // Configuration port
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned CodeDigitsDef = 6;

  // Register reset values
  localparam logic [15:0] OpenTicksRst    = 16'd5000;
  localparam logic [15:0] AlarmTicksRst   = 16'd3000;
  localparam logic [3:0]  MaxFailuresRst  = 4'd3;
  localparam logic [9:0]  NearDistanceRst = 10'd30;
  localparam logic [4:0]  DayFirstRst     = 5'd7;
  localparam logic [4:0]  DayLastRst      = 5'd22;

  localparam logic [3:0] FailSat = 4'hF;

  typedef enum logic [2:0] {
    CFG_OPEN_TICKS    = 3'd0,
    CFG_ALARM_TICKS   = 3'd1,
    CFG_MAX_FAILURES  = 3'd2,
    CFG_NEAR_DISTANCE = 3'd3,
    CFG_DAY_FIRST     = 3'd4,
    CFG_DAY_LAST      = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_KEY    = 2'd1,
    REQ_SAMPLE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    MODE_CLOCK  = 2'd0,
    MODE_ENTRY  = 2'd1,
    MODE_VERIFY = 2'd2,
    MODE_NEW    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KEY_DIGIT,
    KEY_CONFIRM,
    KEY_CHANGE,
    KEY_EXIT,
    KEY_RESTORE,
    KEY_NOP
  } key_kind_e;

  typedef struct packed {
    key_kind_e   kind;
    logic [3:0]  digit;
  } key_t;

  typedef struct packed {
    logic [15:0] open_ticks;
    logic [15:0] alarm_ticks;
    logic [3:0]  max_failures;
    logic [9:0]  near_distance;
    logic [4:0]  day_first_hour;
    logic [4:0]  day_last_hour;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  key_code;
    logic [4:0]  hour_now;
    logic [9:0]  distance_cm;
  } item_t;

  // door_open ends up in bit 0
  typedef struct packed {
    logic [3:0]  failure_count;
    logic [2:0]  digit_position;
    logic [1:0]  lock_mode;
    logic        alarm_on;
    logic        door_open;
  } res_t;

  // Keypad matrix position to key function
  function automatic key_t decode_key(logic [3:0] code);
    key_t k;
    k.kind  = KEY_DIGIT;
    k.digit = 4'd0;
    case (code)
      4'd1:    k.digit = 4'd8;
      4'd2:    k.digit = 4'd4;
      4'd3:    k.digit = 4'd0;
      4'd5:    k.digit = 4'd9;
      4'd6:    k.digit = 4'd5;
      4'd7:    k.digit = 4'd1;
      4'd10:   k.digit = 4'd6;
      4'd11:   k.digit = 4'd2;
      4'd14:   k.digit = 4'd7;
      4'd15:   k.digit = 4'd3;
      4'd8:    k.kind  = KEY_CONFIRM;
      4'd9:    k.kind  = KEY_CHANGE;
      4'd12:   k.kind  = KEY_EXIT;
      4'd13:   k.kind  = KEY_RESTORE;
      default: k.kind  = KEY_NOP;  // keys 0 and 4 are unassigned
    endcase
    return k;
  endfunction

endpackage

[hdl/klc_cfg_regs.sv]
// Configuration register file of the code lock.
module klc_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [klc_pkg::CfgAddrW-1:0]   cfg_addr_i,
  input  logic [klc_pkg::CfgDataW-1:0]   cfg_wdata_i,
  output klc_pkg::cfg_t                  cfg_o
);
  import klc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_OPEN_TICKS:    cfg_d.open_ticks     = cfg_wdata_i;
        CFG_ALARM_TICKS:   cfg_d.alarm_ticks    = cfg_wdata_i;
        CFG_MAX_FAILURES:  cfg_d.max_failures   = cfg_wdata_i[3:0];
        CFG_NEAR_DISTANCE: cfg_d.near_distance  = cfg_wdata_i[9:0];
        CFG_DAY_FIRST:     cfg_d.day_first_hour = cfg_wdata_i[4:0];
        CFG_DAY_LAST:      cfg_d.day_last_hour  = cfg_wdata_i[4:0];
        default: ;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_ticks     <= OpenTicksRst;
      cfg_q.alarm_ticks    <= AlarmTicksRst;
      cfg_q.max_failures   <= MaxFailuresRst;
      cfg_q.near_distance  <= NearDistanceRst;
      cfg_q.day_first_hour <= DayFirstRst;
      cfg_q.day_last_hour  <= DayLastRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/klc_core.sv]
// Lock state registers and the single-pass update for one request.
module klc_core #(
  parameter int unsigned CODE_DIGITS = klc_pkg::CodeDigitsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,   // apply item_i this cycle
  input  klc_pkg::item_t item_i,
  input  klc_pkg::cfg_t  cfg_i,
  output klc_pkg::res_t  res_o     // outputs after item_i
);
  import klc_pkg::*;

  localparam int unsigned PosW = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;

  logic [3:0] dflt_code [CODE_DIGITS];

  for (genvar g = 0; g < CODE_DIGITS; g++) begin : g_dflt
    localparam int unsigned Digit = (CODE_DIGITS - g) % 10;
    assign dflt_code[g] = 4'(Digit);
  end

  mode_e       mode_q, mode_d;
  logic        day_seen_q, day_seen_d;
  logic [3:0]  stored_q [CODE_DIGITS];
  logic [3:0]  stored_d [CODE_DIGITS];
  logic [3:0]  entered_q [CODE_DIGITS];
  logic [3:0]  entered_d [CODE_DIGITS];
  logic [PosW-1:0] pos_q, pos_d;
  logic [3:0]  fail_q, fail_d;
  logic [15:0] door_tmr_q, door_tmr_d;
  logic [15:0] alarm_tmr_q, alarm_tmr_d;
  logic        door_q, door_d;
  logic        alarm_q, alarm_d;

  key_t        key;
  logic        match;
  logic [3:0]  fail_inc;
  logic        miss_hit;
  logic [15:0] door_tmr_inc, alarm_tmr_inc;
  logic        is_day;
  logic [PosW+2:0] pos_ext;

  assign key           = decode_key(item_i.key_code);
  assign fail_inc      = (fail_q != FailSat) ? fail_q + 4'd1 : fail_q;
  assign miss_hit      = (fail_inc >= cfg_i.max_failures);
  assign door_tmr_inc  = door_tmr_q + 16'd1;
  assign alarm_tmr_inc = alarm_tmr_q + 16'd1;
  assign is_day        = (item_i.hour_now >= cfg_i.day_first_hour) &&
                         (item_i.hour_now <= cfg_i.day_last_hour);

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_DIGITS; i++) begin
      if (stored_q[i] != entered_q[i]) match = 1'b0;
    end
  end

  always_comb begin
    mode_d      = mode_q;
    day_seen_d  = day_seen_q;
    stored_d    = stored_q;
    entered_d   = entered_q;
    pos_d       = pos_q;
    fail_d      = fail_q;
    door_tmr_d  = door_tmr_q;
    alarm_tmr_d = alarm_tmr_q;
    door_d      = door_q;
    alarm_d     = alarm_q;

    case (req_e'(item_i.req_type))
      REQ_TICK: begin
        if (door_q) begin
          if (door_tmr_inc >= cfg_i.open_ticks) begin
            door_tmr_d = '0;
            door_d     = 1'b0;
          end else begin
            door_tmr_d = door_tmr_inc;
          end
        end
        if (alarm_q) begin
          if (alarm_tmr_inc >= cfg_i.alarm_ticks) begin
            alarm_tmr_d = '0;
            alarm_d     = 1'b0;
          end else begin
            alarm_tmr_d = alarm_tmr_inc;
          end
        end
      end
      REQ_KEY: begin
        unique case (key.kind)
          KEY_DIGIT: begin
            for (int i = 0; i < CODE_DIGITS; i++) begin
              if (PosW'(i) == pos_q) entered_d[i] = key.digit;
            end
            pos_d = (pos_q == PosW'(CODE_DIGITS - 1)) ? '0 : pos_q + 1'b1;
          end
          KEY_CONFIRM: begin
            unique case (mode_q)
              MODE_ENTRY: begin
                if (match) begin
                  door_d = 1'b1;
                  fail_d = '0;
                end else if (miss_hit) begin
                  fail_d  = '0;
                  alarm_d = 1'b1;
                end else begin
                  fail_d = fail_inc;
                end
              end
              MODE_VERIFY: begin
                if (match) begin
                  mode_d = MODE_NEW;
                  fail_d = '0;
                end else if (miss_hit) begin
                  fail_d  = '0;
                  alarm_d = 1'b1;
                  mode_d  = MODE_ENTRY;
                end else begin
                  fail_d = fail_inc;
                end
              end
              MODE_NEW: begin
                stored_d = entered_q;
                mode_d   = MODE_ENTRY;
              end
              MODE_CLOCK: ;  // confirm ignored in clock view
            endcase
          end
          KEY_CHANGE:  mode_d   = MODE_VERIFY;
          KEY_EXIT:    mode_d   = MODE_ENTRY;
          KEY_RESTORE: stored_d = dflt_code;
          KEY_NOP:     ;
        endcase
      end
      REQ_SAMPLE: begin
        if (is_day) begin
          mode_d = MODE_CLOCK;
          if (item_i.distance_cm <= cfg_i.near_distance) door_d = 1'b1;
        end else if (day_seen_q) begin
          mode_d = MODE_ENTRY;  // first night sample only
        end
        day_seen_d = is_day;
      end
      default: ;  // undefined request type, no change
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_CLOCK;
      day_seen_q  <= 1'b1;
      stored_q    <= dflt_code;
      entered_q   <= '{default: 4'd0};
      pos_q       <= '0;
      fail_q      <= '0;
      door_tmr_q  <= '0;
      alarm_tmr_q <= '0;
      door_q      <= 1'b0;
      alarm_q     <= 1'b0;
    end else if (step_i) begin
      mode_q      <= mode_d;
      day_seen_q  <= day_seen_d;
      stored_q    <= stored_d;
      entered_q   <= entered_d;
      pos_q       <= pos_d;
      fail_q      <= fail_d;
      door_tmr_q  <= door_tmr_d;
      alarm_tmr_q <= alarm_tmr_d;
      door_q      <= door_d;
      alarm_q     <= alarm_d;
    end
  end

  assign pos_ext = {3'b000, pos_d};

  assign res_o.door_open      = door_d;
  assign res_o.alarm_on       = alarm_d;
  assign res_o.lock_mode      = mode_d;
  assign res_o.digit_position = pos_ext[2:0];
  assign res_o.failure_count  = fail_d;

endmodule

[hdl/keypad_code_lock_controller_unit.sv]
// Top level of the keypad code lock controller: stream ports, input and result registers.
//
//  channel   | dir | handshake             | payload (lowest bit first)
//  ----------+-----+-----------------------+------------------------------------------------
//  s_axis    | in  | tvalid / tready       | tuser: req_type; tdata: key_code, hour_now,
//            |     |                       |        distance_cm
//  m_axis    | out | tvalid / tready       | tdata: door_open, alarm_on, lock_mode,
//            |     |                       |        digit_position, failure_count
//  cfg       | in  | cfg_we_i (no wait)    | cfg_addr_i index, cfg_wdata_i value
//
// Every request produces exactly one result. A request is held in the input
// register, is applied to the lock state when it advances and its result is then
// held in the result register; one request per cycle sustained while results are
// taken. Reset brings the valid flags, settings and lock state to their power-up values at
// once; no clearing pass. A stalled result holds the pipe; the input register
// still takes one more request while the result waits.
module keypad_code_lock_controller_unit #(
  parameter int unsigned CODE_DIGITS = klc_pkg::CodeDigitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [klc_pkg::InTdataW-1:0]    s_axis_tdata_i,   // key_code[3:0], hour_now[8:4],
                                                            // distance_cm[18:9], zero fill
  input  logic [klc_pkg::InTuserW-1:0]    s_axis_tuser_i,   // req_type[1:0]
  // result stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [klc_pkg::OutTdataW-1:0]   m_axis_tdata_o,   // door_open[0], alarm_on[1],
                                                            // lock_mode[3:2],
                                                            // digit_position[6:4],
                                                            // failure_count[10:7], zero fill
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [klc_pkg::CfgAddrW-1:0]    cfg_addr_i,
  input  logic [klc_pkg::CfgDataW-1:0]    cfg_wdata_i
);
  import klc_pkg::*;

  cfg_t  cfg;
  item_t in_item_d, in_item_q;
  logic  in_valid_q, in_valid_d;
  res_t  res_next, res_q;
  logic  out_valid_q, out_valid_d;
  logic  s_accept, advance;

  // Request moves into the result register when that slot is free or draining
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  assign in_item_d.req_type    = s_axis_tuser_i;
  assign in_item_d.key_code    = s_axis_tdata_i[3:0];
  assign in_item_d.hour_now    = s_axis_tdata_i[8:4];
  assign in_item_d.distance_cm = s_axis_tdata_i[18:9];

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept)     in_valid_d = 1'b1;
    else if (advance) in_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (advance)              out_valid_d = 1'b1;
    else if (m_axis_tready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (s_accept) in_item_q <= in_item_d;
    if (advance)  res_q     <= res_next;
  end

  klc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  klc_core #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .item_i  (in_item_q),
    .cfg_i   (cfg),
    .res_o   (res_next)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OutTdataW - ResW)'(0), res_q};

endmodule

[hdl/klc_checker.sv]
// Port-level checks for the code lock controller, bound to the top level.
module klc_checker #(
  parameter int unsigned CODE_DIGITS = klc_pkg::CodeDigitsDef
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [klc_pkg::OutTdataW-1:0]   m_axis_tdata_o
);

  // stalled result holds
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // an empty result slot never blocks a request
  a_no_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("request blocked with empty result slot");

  // failures are cleared on reaching the threshold, so the count never saturates
  a_fail_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[10:7] != 4'hF)
    else $error("failure count out of range");

  // digit position stays inside the code
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (CODE_DIGITS <= 8) |->
      32'(m_axis_tdata_o[6:4]) < CODE_DIGITS)
    else $error("digit position past code length");

endmodule

bind keypad_code_lock_controller_unit klc_checker #(
  .CODE_DIGITS (CODE_DIGITS)
) u_klc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

[tb/sv/klc_lock_check.sv]
// Result checker for the keypad code lock: predicts each result and compares it with the block.
`timescale 1ns / 1ps
module klc_lock_check (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  input  logic                          s_ready_i,
  input  logic [klc_pkg::InTdataW-1:0]  s_data_i,   // key_code, hour_now, distance_cm
  input  logic [klc_pkg::InTuserW-1:0]  s_user_i,   // req_type
  input  logic                          m_valid_i,
  input  logic                          m_ready_i,
  input  logic [klc_pkg::OutTdataW-1:0] m_data_i,   // door, alarm, mode, position, failures
  input  logic                          cfg_we_i,
  input  logic [klc_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [klc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output int unsigned                   mismatch_cnt_o,
  output int unsigned                   pending_o,
  output int unsigned                   door_opens_o,
  output int unsigned                   alarms_o
);
  import klc_pkg::*;

  localparam int unsigned Digits = CodeDigitsDef;

  // key values: 0..9 digit, above that a function or none
  localparam logic [4:0] KvConfirm = 5'd16;
  localparam logic [4:0] KvChange  = 5'd17;
  localparam logic [4:0] KvExit    = 5'd18;
  localparam logic [4:0] KvRestore = 5'd19;
  localparam logic [4:0] KvNone    = 5'd31;

  // keypad position 15 (top) down to 0 (bottom), five bits each
  localparam logic [16*5-1:0] KeyTable = {
    5'd3, 5'd7, KvRestore, KvExit, 5'd2, 5'd6, KvChange, KvConfirm,
    5'd1, 5'd5, 5'd9, KvNone, 5'd0, 5'd4, 5'd8, KvNone
  };

  cfg_t                  cfg;
  mode_e                 mode;
  logic                  day_seen;
  logic [4*Digits-1:0]   code_store;
  logic [4*Digits-1:0]   entry;
  logic [2:0]            entry_pos;
  logic [3:0]            misses;
  logic [15:0]           door_tmr;
  logic [15:0]           alarm_tmr;
  logic                  door_on;
  logic                  alarm_on;

  res_t                  lock_state_q [$];
  res_t                  got;
  res_t                  want;
  int unsigned           mismatches;
  int unsigned           checked;
  int unsigned           door_opens;
  int unsigned           alarms;

  function automatic void load_default_code();
    for (int i = 0; i < Digits; i++) code_store[i*4 +: 4] = 4'((Digits - i) % 10);
  endfunction

  // a miss; returns 1 when it sets off the alarm
  function automatic logic count_miss();
    if (misses < FailSat) misses = misses + 4'd1;
    if (misses >= cfg.max_failures) begin
      misses   = '0;
      alarm_on = 1'b1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic res_t advance_lock(logic [1:0] req, logic [3:0] key, logic [4:0] hour,
                                        logic [9:0] dist_cm);
    logic [4:0] kv;
    logic       day;
    logic       door_was;
    logic       alarm_was;
    res_t       r;
    door_was  = door_on;
    alarm_was = alarm_on;
    kv        = KeyTable[key*5 +: 5];
    case (req)
      REQ_TICK: begin
        if (door_on) begin
          door_tmr = door_tmr + 16'd1;
          if (door_tmr >= cfg.open_ticks) begin
            door_tmr = '0;
            door_on  = 1'b0;
          end
        end
        if (alarm_on) begin
          alarm_tmr = alarm_tmr + 16'd1;
          if (alarm_tmr >= cfg.alarm_ticks) begin
            alarm_tmr = '0;
            alarm_on  = 1'b0;
          end
        end
      end
      REQ_KEY: begin
        if (kv <= 5'd9) begin
          if (entry_pos >= Digits) entry_pos = '0;
          entry[entry_pos*4 +: 4] = kv[3:0];
          entry_pos = entry_pos + 3'd1;
          if (entry_pos >= Digits) entry_pos = '0;
        end else begin
          case (kv)
            KvConfirm: begin
              if (mode == MODE_ENTRY) begin
                if (entry == code_store) begin
                  door_on = 1'b1;
                  misses  = '0;
                end else void'(count_miss());
              end else if (mode == MODE_VERIFY) begin
                if (entry == code_store) begin
                  mode   = MODE_NEW;
                  misses = '0;
                end else if (count_miss()) mode = MODE_ENTRY;
              end else if (mode == MODE_NEW) begin
                code_store = entry;
                mode       = MODE_ENTRY;
              end
            end
            KvChange:  mode = MODE_VERIFY;
            KvExit:    mode = MODE_ENTRY;
            KvRestore: load_default_code();
            default: ;
          endcase
        end
      end
      REQ_SAMPLE: begin
        day = (hour >= cfg.day_first_hour) && (hour <= cfg.day_last_hour);
        if (day) begin
          mode = MODE_CLOCK;
          if (dist_cm <= cfg.near_distance) door_on = 1'b1;
        end else if (day_seen) mode = MODE_ENTRY;
        day_seen = day;
      end
      default: ;
    endcase
    if (door_on && !door_was) door_opens++;
    if (alarm_on && !alarm_was) alarms++;
    r.door_open      = door_on;
    r.alarm_on       = alarm_on;
    r.lock_mode      = mode;
    r.digit_position = entry_pos;
    r.failure_count  = misses;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.open_ticks     = OpenTicksRst;
      cfg.alarm_ticks    = AlarmTicksRst;
      cfg.max_failures   = MaxFailuresRst;
      cfg.near_distance  = NearDistanceRst;
      cfg.day_first_hour = DayFirstRst;
      cfg.day_last_hour  = DayLastRst;
      mode       = MODE_CLOCK;
      day_seen   = 1'b1;
      load_default_code();
      entry      = '0;
      entry_pos  = '0;
      misses     = '0;
      door_tmr   = '0;
      alarm_tmr  = '0;
      door_on    = 1'b0;
      alarm_on   = 1'b0;
      lock_state_q.delete();
      mismatches = 0;
      checked    = 0;
      door_opens = 0;
      alarms     = 0;
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
      door_opens_o   <= 0;
      alarms_o       <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_OPEN_TICKS:    cfg.open_ticks     = cfg_wdata_i;
          CFG_ALARM_TICKS:   cfg.alarm_ticks    = cfg_wdata_i;
          CFG_MAX_FAILURES:  cfg.max_failures   = cfg_wdata_i[3:0];
          CFG_NEAR_DISTANCE: cfg.near_distance  = cfg_wdata_i[9:0];
          CFG_DAY_FIRST:     cfg.day_first_hour = cfg_wdata_i[4:0];
          CFG_DAY_LAST:      cfg.day_last_hour  = cfg_wdata_i[4:0];
          default: ;
        endcase
      end
      if (s_valid_i && s_ready_i)
        lock_state_q.push_back(advance_lock(s_user_i, s_data_i[3:0], s_data_i[8:4],
                                            s_data_i[18:9]));
      if (m_valid_i && m_ready_i) begin
        got = res_t'(m_data_i[ResW-1:0]);
        if (lock_state_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: nothing expected, got %h", checked, m_data_i);
        end else begin
          want = lock_state_q.pop_front();
          if (got !== want || m_data_i[OutTdataW-1:ResW] !== '0) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("result %0d: want door %0b alarm %0b mode %0d pos %0d fails %0d",
                       checked, want.door_open, want.alarm_on, want.lock_mode,
                       want.digit_position, want.failure_count);
              $display("result %0d: got door %0b alarm %0b mode %0d pos %0d fails %0d pad %h",
                       checked, got.door_open, got.alarm_on, got.lock_mode,
                       got.digit_position, got.failure_count, m_data_i[OutTdataW-1:ResW]);
            end
          end
        end
        checked++;
      end
      mismatch_cnt_o <= mismatches;
      pending_o      <= lock_state_q.size();
      door_opens_o   <= door_opens;
      alarms_o       <= alarms;
    end
  end

endmodule

[tb/sv/keypad_code_lock_controller_unit_tb.sv]
// Testbench top for the keypad code lock: drives requests, settings and stalls, gives the verdict.
`timescale 1ns / 1ps
module keypad_code_lock_controller_unit_tb;
  import klc_pkg::*;

  localparam int unsigned Digits     = CodeDigitsDef;
  localparam int unsigned QuietLimit = 1000;  // cycles with no request and no result moving
  localparam int unsigned Quota      = 270;   // requests per random phase

  // keypad positions with a function or none, and an unused request type
  localparam logic [3:0] KeyBlank0  = 4'd0;
  localparam logic [3:0] KeyBlank4  = 4'd4;
  localparam logic [3:0] KeyConfirm = 4'd8;
  localparam logic [3:0] KeyChange  = 4'd9;
  localparam logic [3:0] KeyExit    = 4'd12;
  localparam logic [3:0] KeyRestore = 4'd13;
  localparam logic [1:0] ReqUnused  = 2'd3;  // request type with no meaning

  // keypad position for digit d sits at [d*4 +: 4]
  localparam logic [39:0] DigitKeys = {4'd5, 4'd1, 4'd14, 4'd10, 4'd6,
                                       4'd2, 4'd15, 4'd11, 4'd7, 4'd3};
  // codes as packed nibbles, first digit lowest
  localparam logic [4*Digits-1:0] DefaultCode  = 24'h123456;
  localparam logic [4*Digits-1:0] DirectedCode = 24'h370909;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 s_axis_tvalid_i = 1'b0;
  logic                 s_axis_tready_o;
  logic [InTdataW-1:0]  s_axis_tdata_i  = '0;
  logic [InTuserW-1:0]  s_axis_tuser_i  = '0;
  logic                 m_axis_tvalid_o;
  logic                 m_axis_tready_i = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata_o;
  logic                 cfg_we_i        = 1'b0;
  logic [CfgAddrW-1:0]  cfg_addr_i      = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i     = '0;

  int unsigned mismatch_cnt;
  int unsigned pending;
  int unsigned door_opens;
  int unsigned alarms;

  // stimulus bookkeeping
  logic                idle_en     = 1'b1;  // random gaps on both sides when set
  int unsigned         stall_left  = 0;
  int unsigned         quiet_cycles = 0;
  int unsigned         req_cnt     = 0;
  int unsigned         setting_cnt = 1;     // reset values count as the first setting
  int unsigned         pos_track   = 0;     // where the next digit lands in the entry
  logic [4*Digits-1:0] known_code  = DefaultCode;
  logic [9:0]          near_set    = NearDistanceRst;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  keypad_code_lock_controller_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  klc_lock_check u_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_valid_i      (s_axis_tvalid_i),
    .s_ready_i      (s_axis_tready_o),
    .s_data_i       (s_axis_tdata_i),
    .s_user_i       (s_axis_tuser_i),
    .m_valid_i      (m_axis_tvalid_o),
    .m_ready_i      (m_axis_tready_i),
    .m_data_i       (m_axis_tdata_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending),
    .door_opens_o   (door_opens),
    .alarms_o       (alarms)
  );

  // Gap length: mostly none or short, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic is_digit_key(logic [3:0] key);
    return key != KeyBlank0 && key != KeyBlank4 && key != KeyConfirm &&
           key != KeyChange && key != KeyExit && key != KeyRestore;
  endfunction

  // Result side: ready drops for random stretches while idling is on.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left      <= stall_left - 1;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left      <= pick_gap();
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  // Watchdog: a correct block never goes this long without moving a request or a result.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
        (m_axis_tvalid_o && m_axis_tready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("watchdog: no traffic for %0d cycles", QuietLimit);
      $display("keypad_code_lock_controller_unit: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One request: optional gap, then hold valid until the block takes it.
  // Valid stays high across back-to-back requests; it only drops for a gap.
  task automatic send_req(logic [1:0] req, logic [3:0] key, logic [4:0] hour,
                          logic [9:0] dist_cm);
    int unsigned gap;
    gap = idle_en ? pick_gap() : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req;
    s_axis_tdata_i  <= {5'd0, dist_cm, hour, key};
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready_o);
    req_cnt++;
    if (req == REQ_KEY && is_digit_key(key)) pos_track = (pos_track + 1) % Digits;
  endtask

  // unused fields carry random bits so every bit of tdata but the zero fill toggles
  task automatic send_key(logic [3:0] key);
    send_req(REQ_KEY, key, 5'($urandom_range(0, 23)), 10'($urandom_range(0, 999)));
  endtask

  task automatic send_tick();
    send_req(REQ_TICK, 4'($urandom), 5'($urandom_range(0, 23)), 10'($urandom_range(0, 999)));
  endtask

  task automatic send_sample(logic [4:0] hour, logic [9:0] dist_cm);
    send_req(REQ_SAMPLE, 4'($urandom), hour, dist_cm);
  endtask

  // Types a code so that it lines up with the entry's current write position.
  // bad >= 0 corrupts that digit.
  task automatic enter_digits(logic [4*Digits-1:0] code, int bad);
    int unsigned start;
    int unsigned p;
    logic [3:0]  d;
    start = pos_track;
    for (int j = 0; j < Digits; j++) begin
      p = (start + j) % Digits;
      d = code[p*4 +: 4];
      if (p == bad) d = (d == 4'd9) ? 4'd0 : d + 4'd1;
      send_key(DigitKeys[d*4 +: 4]);
    end
  endtask

  task automatic press_restore();
    send_key(KeyRestore);
    known_code = DefaultCode;
  endtask

  // exit to entry, type the code (one digit wrong now and then), confirm
  task automatic try_open();
    int bad;
    bad = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, Digits - 1)) : -1;
    send_key(KeyExit);
    enter_digits(known_code, bad);
    send_key(KeyConfirm);
  endtask

  // change key, old code, confirm, new code, confirm
  task automatic try_change();
    logic [4*Digits-1:0] fresh;
    int                  bad;
    bad = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, Digits - 1)) : -1;
    for (int i = 0; i < Digits; i++) fresh[i*4 +: 4] = 4'($urandom_range(0, 9));
    send_key(KeyChange);
    enter_digits(known_code, bad);
    send_key(KeyConfirm);
    enter_digits(fresh, -1);
    send_key(KeyConfirm);
    if (bad < 0) known_code = fresh;
  endtask

  // Stop sending and wait until every result is back and the pipe has drained.
  task automatic quiesce();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // all six registers, only with the block idle
  task automatic load_settings(logic [15:0] open_t, logic [15:0] alarm_t, logic [3:0] max_f,
                               logic [9:0] near, logic [4:0] first_h, logic [4:0] last_h);
    quiesce();
    write_reg(CFG_OPEN_TICKS, open_t);
    write_reg(CFG_ALARM_TICKS, alarm_t);
    write_reg(CFG_MAX_FAILURES, 16'(max_f));
    write_reg(CFG_NEAR_DISTANCE, 16'(near));
    write_reg(CFG_DAY_FIRST, 16'(first_h));
    write_reg(CFG_DAY_LAST, 16'(last_h));
    near_set = near;
    setting_cnt++;
  endtask

  // Mostly well-formed key sequences with random content; the rest is
  // samples, tick bursts and plain noise.
  task automatic run_random(int unsigned quota);
    int unsigned stop_at;
    int unsigned r;
    int unsigned n;
    stop_at = req_cnt + quota;
    while (req_cnt < stop_at) begin
      idle_en <= ($urandom_range(0, 4) != 0);
      r = $urandom_range(0, 99);
      if (r < 20) begin
        try_open();
      end else if (r < 30) begin
        try_change();
      end else if (r < 34) begin
        press_restore();
      end else if (r < 50) begin
        send_sample(5'($urandom_range(0, 23)), ($urandom_range(0, 1) != 0) ?
                    10'($urandom_range(0, near_set)) : 10'($urandom_range(0, 999)));
      end else if (r < 75) begin
        n = $urandom_range(1, 40);
        repeat (n) send_tick();
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_req(2'($urandom_range(0, 2)), 4'($urandom),
                            5'($urandom_range(0, 23)), 10'($urandom_range(0, 999)));
      end
    end
  endtask

  initial begin
    logic [4:0]  first_h;
    logic [4:0]  last_h;
    logic [3:0]  max_f;

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // --- directed part, reset settings ---
    send_tick();                          // tick with nothing running
    send_key(KeyConfirm);                 // confirm in clock view is ignored
    send_key(DigitKeys[0 +: 4]);          // digit in clock view still lands
    send_key(KeyBlank0);                  // keys without function
    send_key(KeyBlank4);
    send_req(ReqUnused, 4'hF, 5'd23, 10'd999);  // request type with no meaning
    send_sample(5'd12, 10'd999);          // daytime, no echo
    send_sample(5'd7, 10'd30);            // first day hour, distance at the limit: opens
    send_sample(5'd22, 10'd0);            // last day hour, opens again while open
    send_sample(5'd23, 10'd500);          // nightfall forces entry
    send_sample(5'd0, 10'd0);             // later night sample leaves mode alone
    press_restore();
    send_key(KeyChange);
    send_key(KeyConfirm);                 // miss while verifying the old code
    enter_digits(known_code, -1);         // entry position is not at zero here
    send_key(KeyConfirm);                 // old code accepted
    enter_digits(DirectedCode, -1);
    send_key(KeyConfirm);                 // new code stored
    known_code = DirectedCode;
    send_key(KeyExit);

    // --- low extremes: one-tick timers, one miss alarms, always daytime ---
    load_settings(16'd1, 16'd1, 4'd1, 10'd0, 5'd0, 5'd23);
    run_random(Quota);

    // --- high extremes: timers never expire here, first hour after last hour ---
    load_settings(16'hFFFF, 16'hFFFF, 4'd15, 10'd999, 5'd23, 5'd0);
    run_random(Quota);

    // --- random settings, short timers so doors and alarms cycle ---
    for (int ph = 0; ph < 5; ph++) begin
      first_h = 5'($urandom_range(0, 23));
      last_h  = ($urandom_range(0, 3) != 0) ? 5'($urandom_range(first_h, 23)) :
                                               5'($urandom_range(0, 23));
      max_f   = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 4)) :
                                             4'($urandom_range(5, 15));
      load_settings(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)), max_f,
                    10'($urandom_range(0, 999)), first_h, last_h);
      run_random(Quota);
    end

    // drain, then wait on so a stray result would still be caught
    quiesce();
    repeat (8) @(negedge clk_i);
    $display("covered %0d requests across %0d lock settings", req_cnt, setting_cnt);
    $display("door opened %0d times, alarm sounded %0d times, %0d bad results",
             door_opens, alarms, mismatch_cnt);
    if (mismatch_cnt == 0) begin
      $display("keypad_code_lock_controller_unit: match");
    end else begin
      $display("keypad_code_lock_controller_unit: mismatch");
    end
    $finish;
  end

endmodule
